>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DEQ_DEPTH = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

>>> rtl/deq_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_if
// Valid/ready channels of the queue: operation request and result.
// ---------------------------------------------------------------------------
interface deq_in_if;
  logic                               valid;
  logic                               ready;
  logic [deq_pkg::OP_W-1:0]           opcode;
  logic signed [deq_pkg::DATA_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface deq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [deq_pkg::DATA_W-1:0]  data;
  logic [deq_pkg::STAT_W-1:0]         status;
  logic [deq_pkg::OCC_W-1:0]          occupancy;

  modport source (output valid, output data, output status, output occupancy, input ready);
  modport sink   (input valid, input data, input status, input occupancy, output ready);
endinterface

>>> rtl/deq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned DEPTH  = deq_pkg::DEQ_DEPTH,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned DATA_W = deq_pkg::DATA_W
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a ring-addressed RAM.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per transfer: opcode (push front, push rear,
//   pop front, pop rear) and the value to push. out_o returns exactly one
//   result per operation, in order: data (popped value, or the pushed value
//   echoed, zero on error), status (ok, pop on empty, push on full) and the
//   occupancy after the operation.
//   A push, or any operation that fails, has its result on out_o in the cycle
//   after the transfer, and the next operation can follow at once: one per
//   cycle while the receiver takes each result. A successful pop goes through
//   the synchronous RAM read and the read state into the output register, and
//   in_i takes no new operation until the read state is left.
//   The result sits in an output register; while the receiver stalls it is
//   held and in_i takes a new operation only in the cycle the held result
//   is transferred. Reset empties the queue (head and count cleared); RAM
//   contents are not cleared, since only written entries are ever read.
// ---------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  deq_pkg::state_e  state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic                              out_valid_q, out_valid_d;
  logic signed [deq_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic [deq_pkg::STAT_W-1:0]        out_status_q, out_status_d;
  logic [deq_pkg::OCC_W-1:0]         out_occ_q, out_occ_d;

  deq_pkg::opcode_e op;
  logic             accept;
  logic             is_push;
  logic             full;
  logic             empty;
  logic             pop_read;

  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;
  logic [SUM_W-1:0] rear_sum;
  logic [SUM_W-1:0] rear_sum_m1;
  logic [IDX_W-1:0] rear_push_slot;
  logic [IDX_W-1:0] rear_pop_slot;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic                       ram_re;
  logic [IDX_W-1:0]           ram_raddr;
  logic [deq_pkg::DATA_W-1:0] ram_rdata;

  assign op      = deq_pkg::opcode_e'(in_i.opcode);
  assign accept  = in_i.valid && in_i.ready;
  assign is_push = (op == deq_pkg::OP_PUSH_FRONT) || (op == deq_pkg::OP_PUSH_REAR);
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign pop_read = accept && !is_push && !empty;

  assign in_i.ready      = (state_q == deq_pkg::S_IDLE) && (!out_valid_q || out_o.ready);
  assign out_o.valid     = out_valid_q;
  assign out_o.data      = out_data_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;

  // ring arithmetic, sums stay below twice the depth
  assign head_dec    = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc    = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign rear_sum    = SUM_W'(head_q) + SUM_W'(count_q);
  assign rear_sum_m1 = rear_sum - 1'b1;
  assign rear_push_slot = (rear_sum >= SUM_W'(DEPTH))
                        ? IDX_W'(rear_sum - SUM_W'(DEPTH)) : IDX_W'(rear_sum);
  assign rear_pop_slot  = (rear_sum_m1 >= SUM_W'(DEPTH))
                        ? IDX_W'(rear_sum_m1 - SUM_W'(DEPTH)) : IDX_W'(rear_sum_m1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (pop_read) begin
          state_d = deq_pkg::S_READ;
        end
      end
      deq_pkg::S_READ: begin
        state_d = deq_pkg::S_IDLE;
      end
      default: begin
        state_d = deq_pkg::S_IDLE;
      end
    endcase
  end

  // RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rear_push_slot;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept && is_push && !full) begin
          ram_we    = 1'b1;
          ram_waddr = (op == deq_pkg::OP_PUSH_FRONT) ? head_dec : rear_push_slot;
        end
        if (pop_read) begin
          ram_re    = 1'b1;
          ram_raddr = (op == deq_pkg::OP_POP_FRONT) ? head_q : rear_pop_slot;
        end
      end
      deq_pkg::S_READ: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // pointers and output register
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;

    if (state_q == deq_pkg::S_READ) begin
      out_valid_d  = 1'b1;
      out_data_d   = ram_rdata;
      out_status_d = deq_pkg::ST_OK;
      out_occ_d    = deq_pkg::OCC_W'(count_q);
    end else if (accept) begin
      unique case (op)
        deq_pkg::OP_PUSH_FRONT,
        deq_pkg::OP_PUSH_REAR: begin
          out_valid_d = 1'b1;
          if (full) begin
            out_data_d   = '0;
            out_status_d = deq_pkg::ST_FULL;
            out_occ_d    = deq_pkg::OCC_W'(count_q);
          end else begin
            if (op == deq_pkg::OP_PUSH_FRONT) begin
              head_d = head_dec;
            end
            count_d      = count_q + 1'b1;
            out_data_d   = in_i.value;
            out_status_d = deq_pkg::ST_OK;
            out_occ_d    = deq_pkg::OCC_W'(count_q + 1'b1);
          end
        end
        deq_pkg::OP_POP_FRONT,
        deq_pkg::OP_POP_REAR: begin
          if (empty) begin
            out_valid_d  = 1'b1;
            out_data_d   = '0;
            out_status_d = deq_pkg::ST_EMPTY;
            out_occ_d    = deq_pkg::OCC_W'(count_q);
          end else begin
            // result loads from the RAM in the read state
            out_valid_d = 1'b0;
            if (op == deq_pkg::OP_POP_FRONT) begin
              head_d = head_inc;
            end
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  deq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (deq_pkg::DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the read state never finds a held result in the output register
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == deq_pkg::S_READ |-> !out_valid_q)
    else $error("output register busy when pop data returns");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_read_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == deq_pkg::S_READ |-> $past(pop_read))
    else $error("read state without a pop transfer");

  a_full_push_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_push && full |=> count_q == $past(count_q) && head_q == $past(head_q))
    else $error("push on full queue changed state");

  a_no_write_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> !ram_we)
    else $error("RAM read and write in the same cycle");

endmodule
